[rtl/msri_pkg.sv]
package msri_pkg;

  localparam int unsigned SpdW   = 16;  // signed speeds
  localparam int unsigned PosW   = 32;  // signed position
  localparam int unsigned MaxW   = 15;  // max speed register
  localparam int unsigned AccW   = 16;  // acceleration register
  localparam int unsigned MsW    = 5;   // per-tick step scale, 1..25
  localparam int unsigned DivNW  = 34;  // divider dividend / quotient width
  localparam int unsigned DivDW  = 22;  // divider divisor / remainder width
  localparam int unsigned DivCW  = 6;   // divider iteration counter
  localparam int unsigned StepNW = 21;  // step numerator width
  localparam int unsigned DiffW  = 17;  // exact speed difference

  localparam logic [MsW-1:0]    StepCap     = 5'd25;
  localparam logic [AccW-1:0]   AccSatLimit = 16'd5000;    // 25 * 200
  localparam logic [12:0]       AccRecip    = 13'd5243;    // ~2^20 / 200
  localparam logic [32:0]       PosJumpMax  = 33'd1000000;
  localparam logic [MaxW-1:0]   MaxSpeedRst = 15'd100;
  localparam logic [AccW-1:0]   AccelRst    = 16'd1;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET_SPD = 3'd1,
    CMD_SET_POS = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_ESTOP   = 3'd4,
    CMD_RAISE   = 3'd5,
    CMD_CLEAR   = 3'd6
  } cmd_e;

  typedef enum logic {
    REG_MAX_SPEED  = 1'b0,
    REG_ACCEL_RATE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_STEP,
    ST_PMUL,
    ST_PADD,
    ST_FIN
  } state_e;

  typedef enum logic {
    PH_STEP = 1'b0,
    PH_POS  = 1'b1
  } phase_e;

endpackage

[rtl/motor_speed_ramp_integrator_unit.sv]
// Channel   | Dir | Handshake               | Payload, lowest bit first
// ----------+-----+-------------------------+--------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tuser: cmd[2:0]
//           |     |                         | tdata: speed_value[15:0], position_value[47:16]
// m_axis    | out | m_axis_tvalid/tready    | tdata: accepted[0], speed_now[16:1],
//           |     |                         | position_now[48:17], moving_flag[49],
//           |     |                         | error_flag[50], zero fill [55:51]
// cfg       | in  | cfg_we_i                | cfg_idx_i, cfg_data_i[15:0]
//
// Every command other than an active tick passes through the execute and final states.
// An active tick runs one shared restoring divider that produces one
// quotient bit per cycle, 21 bits for the speed step and 34 bits for the position increment.
// rst_ni clears all motor state and loads max_speed = 100 and accel_rate = 1.
// s_axis_tready is high only in the idle state; a result waiting in the output
// register that is not taken holds the sequencer in its final state, and so blocks the next beat.
module motor_speed_ramp_integrator_unit
  import msri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // speed_value[15:0], position_value[47:16]
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // accepted, speed_now, position_now, moving, error
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [MaxW-1:0] max_speed_q;
  logic [AccW-1:0] accel_q;

  // Motor state.
  logic signed [SpdW-1:0] target_q, target_d;
  logic signed [SpdW-1:0] current_q, current_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   moving_q, moving_d;
  logic                   fault_q, fault_d;

  // Sequencer and latched command.
  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  cmd_e                   cmd_q, cmd_d;
  logic signed [SpdW-1:0] sv_q, sv_d;
  logic signed [PosW-1:0] pv_q, pv_d;
  logic [MsW-1:0]         ms_q, ms_d;
  logic                   ok_q, ok_d;

  // Shared divider.
  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dvs_q, dvs_d;
  logic [DivCW-1:0] cnt_q, cnt_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [55:0] out_data_q, out_data_d;

  logic s_fire, out_free;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Effective divisor: a zero max speed acts as one in the curves.
  logic [MaxW-1:0] meff;
  assign meff = (max_speed_q == '0) ? MaxW'(1) : max_speed_q;

  // Step scale from the acceleration setting. Below the saturation point the
  // reciprocal product is exact; at or above it the scale is capped.
  logic [25:0]    acc_prod;
  logic [MsW-1:0] acc_quo, ms_calc;
  assign acc_prod = accel_q[12:0] * AccRecip;
  assign acc_quo  = acc_prod[24:20];
  always_comb begin
    if (accel_q >= AccSatLimit) begin
      ms_calc = StepCap;
    end else if (acc_quo == '0) begin
      ms_calc = MsW'(1);
    end else begin
      ms_calc = acc_quo;
    end
  end

  // Speed difference, its magnitude and the clamped difference.
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        dabs;
  logic [MaxW-1:0]         dmin;
  logic [MsW-1:0]          step_hi;
  logic [StepNW-1:0]       step_num;
  assign diff     = DiffW'(target_q) - DiffW'(current_q);
  assign dabs     = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign dmin     = (dabs < DiffW'(meff)) ? dabs[MaxW-1:0] : meff;
  assign step_hi  = (dabs < DiffW'(StepCap)) ? dabs[MsW-1:0] : StepCap;
  assign step_num = StepNW'(ms_q * ({1'b0, meff} + {1'b0, dmin}));

  // Step from the divider's quotient, clamped to 1 .. min(d, 25).
  logic [StepNW-1:0] step_quo;
  logic [MsW-1:0]    step;
  assign step_quo = quo_q[StepNW-1:0];
  always_comb begin
    if (step_quo == '0) begin
      step = MsW'(1);
    end else if (step_quo > StepNW'(step_hi)) begin
      step = step_hi;
    end else begin
      step = step_quo[MsW-1:0];
    end
  end

  // Position increment numerator |s| * (7M + 3|s|) and divisor 100M.
  logic [SpdW-1:0]  sabs;
  logic [19:0]      pcoef;
  logic [35:0]      pprod;
  logic [DivDW-1:0] hundred_m;
  assign sabs      = current_q[SpdW-1] ? SpdW'(-current_q) : SpdW'(current_q);
  assign pcoef     = ({5'b0, meff} << 3) - {5'b0, meff} + ({4'b0, sabs} << 1) + {4'b0, sabs};
  assign pprod     = sabs * pcoef;
  assign hundred_m = meff * 7'd100;

  // One restoring step of the shared divider.
  logic [DivDW+1:0] trial;
  assign trial = {1'b0, rem_q, quo_q[DivNW-1]} - {2'b0, dvs_q};

  // Checks for the set commands.
  logic [SpdW:0]         sv_abs;
  logic signed [32:0]    pdiff;
  logic [32:0]           pdiff_abs;
  assign sv_abs    = sv_q[SpdW-1] ? (SpdW+1)'(-sv_q) : (SpdW+1)'(sv_q);
  assign pdiff     = 33'(pv_q) - 33'($signed(pos_q));
  assign pdiff_abs = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_TICK && moving_q && !fault_q) begin
          state_d = (diff != '0) ? ST_DIV : ST_PMUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (cnt_q == DivCW'(1)) begin
          state_d = (phase_q == PH_STEP) ? ST_STEP : ST_PADD;
        end
      end
      ST_STEP: state_d = ST_PMUL;
      ST_PMUL: state_d = (current_q != '0) ? ST_DIV : ST_FIN;
      ST_PADD: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    target_d    = target_q;
    current_d   = current_q;
    pos_d       = pos_q;
    moving_d    = moving_q;
    fault_d     = fault_q;
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    sv_d        = sv_q;
    pv_d        = pv_q;
    ms_d        = ms_q;
    ok_d        = ok_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          cmd_d = cmd_e'(s_axis_tuser);
          sv_d  = s_axis_tdata[15:0];
          pv_d  = s_axis_tdata[47:16];
          ms_d  = ms_calc;
          ok_d  = 1'b0;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_TICK: begin
            if (moving_q && !fault_q) begin
              ok_d    = 1'b1;
              phase_d = PH_STEP;
              quo_d   = {step_num, {(DivNW-StepNW){1'b0}}};
              rem_d   = '0;
              dvs_d   = DivDW'({meff, 1'b0});
              cnt_d   = DivCW'(StepNW);
            end
          end
          CMD_SET_SPD: begin
            if (!fault_q) begin
              if (sv_abs > (SpdW+1)'(max_speed_q)) begin
                fault_d = 1'b1;
              end else begin
                target_d = sv_q;
                moving_d = (sv_q != '0);
                ok_d     = 1'b1;
              end
            end
          end
          CMD_SET_POS: begin
            if (!fault_q) begin
              if (pdiff_abs > PosJumpMax) begin
                fault_d = 1'b1;
              end else begin
                pos_d    = pv_q;
                moving_d = 1'b1;
                ok_d     = 1'b1;
              end
            end
          end
          CMD_STOP: begin
            if (!fault_q) begin
              target_d  = '0;
              current_d = '0;
              moving_d  = 1'b0;
              ok_d      = 1'b1;
            end
          end
          CMD_ESTOP: begin
            target_d  = '0;
            current_d = '0;
            moving_d  = 1'b0;
            fault_d   = 1'b1;
            ok_d      = 1'b1;
          end
          CMD_RAISE: begin
            fault_d = 1'b1;
            ok_d    = 1'b1;
          end
          CMD_CLEAR: begin
            fault_d = 1'b0;
            ok_d    = 1'b1;
          end
          default: ok_d = 1'b0;
        endcase
      end
      ST_DIV: begin
        if (!trial[DivDW+1]) begin
          rem_d = trial[DivDW-1:0];
          quo_d = {quo_q[DivNW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DivDW-2:0], quo_q[DivNW-1]};
          quo_d = {quo_q[DivNW-2:0], 1'b0};
        end
        cnt_d = cnt_q - DivCW'(1);
      end
      ST_STEP: begin
        if (diff[DiffW-1]) begin
          current_d = current_q - SpdW'(step);
        end else begin
          current_d = current_q + SpdW'(step);
        end
      end
      ST_PMUL: begin
        phase_d = PH_POS;
        quo_d   = pprod[DivNW-1:0];
        rem_d   = '0;
        dvs_d   = hundred_m;
        cnt_d   = DivCW'(DivNW);
      end
      ST_PADD: begin
        if (current_q[SpdW-1]) begin
          pos_d = pos_q - quo_q[PosW-1:0];
        end else begin
          pos_d = pos_q + quo_q[PosW-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'b0, fault_q, moving_q, pos_q, current_q, ok_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedRst;
      accel_q     <= AccelRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_SPEED:  max_speed_q <= cfg_data_i[MaxW-1:0];
        REG_ACCEL_RATE: accel_q     <= cfg_data_i[AccW-1:0];
        default: ;
      endcase
    end
  end

  // Control and motor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_STEP;
      target_q    <= '0;
      current_q   <= '0;
      pos_q       <= '0;
      moving_q    <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      target_q    <= target_d;
      current_q   <= current_d;
      pos_q       <= pos_d;
      moving_q    <= moving_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    sv_q       <= sv_d;
    pv_q       <= pv_d;
    ms_q       <= ms_d;
    ok_q       <= ok_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    out_data_q <= out_data_d;
  end

endmodule

[tb/motor_ramp_checker.sv]
module motor_ramp_checker
  import msri_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tready,
  input  logic [47:0]     s_axis_tdata,   // speed_value[15:0], position_value[47:16]
  input  logic [2:0]      s_axis_tuser,   // cmd[2:0]
  input  logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  logic [55:0]     m_axis_tdata,   // accepted, speed_now, position_now, moving, error
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  output int              mismatch_o,
  output int              pending_o,
  output logic [PosW-1:0] position_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint AccelDiv  = 200;
  localparam longint CurveLin  = 7;
  localparam longint CurveQuad = 3;
  localparam longint CurveDiv  = 100;
  localparam int     ReportMax = 10;

  // Result beat as it sits in m_axis_tdata[50:0], highest field first.
  typedef struct packed {
    logic                   fault;
    logic                   moving;
    logic signed [PosW-1:0] pos;
    logic signed [SpdW-1:0] speed;
    logic                   accepted;
  } motor_status_t;

  motor_status_t expected_status_q[$];
  motor_status_t want_s, got_s;

  logic [MaxW-1:0]        lim_speed;
  logic [AccW-1:0]        accel_set;
  logic signed [SpdW-1:0] tgt_speed;
  logic signed [SpdW-1:0] cur_speed;
  logic [PosW-1:0]        motor_pos;
  logic                   run_flag;
  logic                   fault_flag;

  // Ramp the speed one step toward the target, then integrate the position.
  task automatic ramp_tick();
    longint m, ms, diff, d, dm, step, hi, a, inc, nxt;
    m  = (lim_speed == '0) ? 1 : longint'(lim_speed);
    ms = longint'(accel_set) / AccelDiv;
    if (ms < 1) ms = 1;
    if (ms > longint'(StepCap)) ms = longint'(StepCap);
    diff = longint'(tgt_speed) - longint'(cur_speed);
    if (diff != 0) begin
      d    = (diff < 0) ? -diff : diff;
      dm   = (d < m) ? d : m;
      step = ms * (m + dm) / (2 * m);
      hi   = (d < longint'(StepCap)) ? d : longint'(StepCap);
      if (step < 1) step = 1;
      if (step > hi) step = hi;
      nxt = (diff > 0) ? longint'(cur_speed) + step : longint'(cur_speed) - step;
      cur_speed = nxt[SpdW-1:0];
    end
    a = longint'(cur_speed);
    if (a < 0) a = -a;
    if (a != 0) begin
      inc = a * (CurveLin * m + CurveQuad * a) / (CurveDiv * m);
      if (cur_speed > 0) motor_pos = motor_pos + inc[PosW-1:0];
      else motor_pos = motor_pos - inc[PosW-1:0];
    end
  endtask

  task automatic execute_command(input logic [2:0] cmd, input logic signed [SpdW-1:0] sv,
                                 input logic signed [PosW-1:0] pv, output motor_status_t res);
    longint mag;
    longint jump;
    logic   ok;
    ok = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (run_flag && !fault_flag) begin
          ramp_tick();
          ok = 1'b1;
        end
      end
      CMD_SET_SPD: begin
        if (!fault_flag) begin
          mag = longint'(sv);
          if (mag < 0) mag = -mag;
          if (mag > longint'(lim_speed)) begin
            fault_flag = 1'b1;
          end else begin
            tgt_speed = sv;
            run_flag  = (sv != 0);
            ok        = 1'b1;
          end
        end
      end
      CMD_SET_POS: begin
        if (!fault_flag) begin
          jump = longint'(pv) - longint'($signed(motor_pos));
          if (jump < 0) jump = -jump;
          if (jump > longint'(PosJumpMax)) begin
            fault_flag = 1'b1;
          end else begin
            motor_pos = pv;
            run_flag  = 1'b1;
            ok        = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (!fault_flag) begin
          tgt_speed = '0;
          cur_speed = '0;
          run_flag  = 1'b0;
          ok        = 1'b1;
        end
      end
      CMD_ESTOP: begin
        tgt_speed  = '0;
        cur_speed  = '0;
        run_flag   = 1'b0;
        fault_flag = 1'b1;
        ok         = 1'b1;
      end
      CMD_RAISE: begin
        fault_flag = 1'b1;
        ok         = 1'b1;
      end
      CMD_CLEAR: begin
        fault_flag = 1'b0;
        ok         = 1'b1;
      end
      default: begin
      end
    endcase
    res = '{fault_flag, run_flag, motor_pos, cur_speed, ok};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_speed  = MaxSpeedRst;
      accel_set  = AccelRst;
      tgt_speed  = '0;
      cur_speed  = '0;
      motor_pos  = '0;
      run_flag   = 1'b0;
      fault_flag = 1'b0;
      mismatch_o = 0;
      expected_status_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MAX_SPEED) lim_speed = cfg_data_i[MaxW-1:0];
        else accel_set = cfg_data_i[AccW-1:0];
      end
      // Results are matched before new commands are predicted, so a stray result
      // can never be paired with a command accepted on the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got_s = motor_status_t'(m_axis_tdata[50:0]);
        if (expected_status_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= ReportMax)
            $display("unexpected result beat %h with no command outstanding", m_axis_tdata);
        end else begin
          want_s = expected_status_q.pop_front();
          if (got_s !== want_s || m_axis_tdata[55:51] !== '0) begin
            mismatch_o++;
            if (mismatch_o <= ReportMax)
              $display("result mismatch: expected acc=%0b spd=%0d pos=%0d mov=%0b err=%0b, got acc=%0b spd=%0d pos=%0d mov=%0b err=%0b fill=%h",
                       want_s.accepted, want_s.speed, want_s.pos, want_s.moving, want_s.fault,
                       got_s.accepted, got_s.speed, got_s.pos, got_s.moving, got_s.fault,
                       m_axis_tdata[55:51]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        execute_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16], want_s);
        expected_status_q.push_back(want_s);
      end
    end
    pending_o  = expected_status_q.size();
    position_o = motor_pos;
  end

endmodule

[tb/motor_speed_ramp_integrator_unit_test.sv]
module motor_speed_ramp_integrator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import msri_pkg::*;

  // The top only produces stimulus and decides the verdict; all prediction and
  // comparison lives in the checker instantiated next to the block.

  localparam int         NumPhases    = 6;
  localparam int         PhaseBeats   = 105;
  localparam int         HoldCycles   = 400;
  localparam int         HoldAfter    = 40;
  localparam int         SettleCycles = 80;
  localparam int         CycleLimit   = 1000000;
  localparam logic [2:0] CmdUnused    = 3'd7;
  localparam longint     PosJump      = longint'(PosJumpMax);

  // Register settings per phase. They walk both registers through their extremes,
  // including zero, and the max speed write of the last phase carries a stray top
  // bit that the 15-bit register has to drop.
  localparam logic [15:0] PhaseMax   [NumPhases] = '{16'd32767, 16'd0, 16'd1, 16'd60,
                                                     16'd1000, 16'h81F4};
  localparam logic [15:0] PhaseAccel [NumPhases] = '{16'hFFFF, 16'd0, 16'd200, 16'd5000,
                                                     16'd4999, 16'd399};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata   = '0;   // speed_value[15:0], position_value[47:16]
  logic [2:0]  s_axis_tuser   = CMD_TICK;   // cmd[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [55:0] m_axis_tdata;    // accepted, speed_now, position_now, moving, error
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = REG_MAX_SPEED;
  logic [15:0] cfg_data_i     = '0;

  int              mismatch_cnt;
  int              results_owed;
  logic [PosW-1:0] motor_pos_pred;

  int tx_idle_pct = 20;
  int rx_idle_pct = 48;
  int beats_sent  = 0;
  int speed_lim   = int'(MaxSpeedRst);
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int cycle_cnt   = 0;

  motor_speed_ramp_integrator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  motor_ramp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatch_o    (mismatch_cnt),
    .pending_o     (results_owed),
    .position_o    (motor_pos_pred)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side. Once enough beats have gone in, the receiver holds off for a long
  // stretch so the result register stays full and the block stops taking commands
  // while the sender keeps offering. Otherwise it stalls at the rate of the phase.
  always @(negedge clk_i) begin
    if (!hold_done && beats_sent >= HoldAfter) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offers one command beat. It is entered at a falling edge and returns at the
  // falling edge after the beat was taken, with tvalid still high so that a
  // following beat can go out back to back.
  task automatic send_beat(input logic [2:0] cmd, input int spd, input longint pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pos[31:0], spd[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every outstanding result has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  // Both registers are written on consecutive cycles while the block is idle.
  task automatic write_config(input logic [15:0] max_val, input logic [15:0] accel_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_SPEED;
    cfg_data_i <= max_val;
    @(negedge clk_i);
    cfg_idx_i  <= REG_ACCEL_RATE;
    cfg_data_i <= accel_val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 16'($urandom);
  endtask

  // Target speed for a motion run: mostly inside the limit, sometimes one past it
  // so that the run breaks on a fault.
  function automatic int pick_speed();
    int v;
    if ($urandom_range(9) == 0) begin
      v = speed_lim + 1;
      if ($urandom_range(1)) v = -v;
    end else if (speed_lim == 0) begin
      v = 0;
    end else begin
      v = int'($urandom_range(2 * speed_lim)) - speed_lim;
    end
    return v;
  endfunction

  // A new position near the predicted one, with the jump limit and one past it
  // hit on purpose.
  function automatic longint near_position();
    longint offs;
    case ($urandom_range(9))
      0:       offs = PosJump;
      1:       offs = -PosJump;
      2:       offs = PosJump + 1;
      3:       offs = -PosJump - 1;
      default: offs = longint'($urandom_range(2 * PosJump)) - PosJump;
    endcase
    return longint'($signed(motor_pos_pred)) + offs;
  endfunction

  // A well-formed motion run: clear any fault, set a target, maybe relocate, then
  // a burst of ticks with the occasional retarget, relocation or stop mixed in. Fields that a
  // command ignores carry random bits.
  task automatic run_motion_sequence();
    int ticks;
    send_beat(CMD_CLEAR, $urandom, $urandom);
    send_beat(CMD_SET_SPD, pick_speed(), $urandom);
    if ($urandom_range(99) < 40) send_beat(CMD_SET_POS, $urandom, near_position());
    ticks = $urandom_range(20, 3);
    repeat (ticks) begin
      case ($urandom_range(19))
        0:       send_beat(CMD_SET_SPD, pick_speed(), $urandom);
        1:       send_beat(CMD_STOP, $urandom, $urandom);
        2:       send_beat(CMD_SET_POS, $urandom, near_position());
        default: send_beat(CMD_TICK, $urandom, $urandom);
      endcase
    end
  endtask

  // Noise: any command code, unused one included, random speed, random or nearby position.
  task automatic send_noise();
    logic [2:0] cmd;
    cmd = $urandom_range(CmdUnused);
    if ($urandom_range(1)) send_beat(cmd, $urandom, $urandom);
    else send_beat(cmd, $urandom, near_position());
  endtask

  initial begin
    int  stop_at;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, still on the reset settings (max speed 100, slowest ramp).
    send_beat(CMD_TICK, 0, 0);                          // idle tick while not moving
    send_beat(CmdUnused, 16'h8000, 32'h8000_0000);      // unused code is ignored
    send_beat(CMD_SET_SPD, 100, 0);                     // exactly at the limit
    send_beat(CMD_TICK, 0, 0);
    send_beat(CMD_TICK, 0, 0);
    send_beat(CMD_SET_SPD, 101, 0);                     // one past the limit faults
    send_beat(CMD_SET_SPD, 5, 0);                       // refused under fault
    send_beat(CMD_TICK, 0, 0);                          // no motion under fault
    send_beat(CMD_STOP, 0, 0);                          // refused under fault
    send_beat(CMD_CLEAR, 0, 0);
    send_beat(CMD_SET_SPD, -100, 0);
    send_beat(CMD_TICK, 0, 0);
    send_beat(CMD_SET_POS, 0, longint'($signed(motor_pos_pred)) + PosJump);
    send_beat(CMD_SET_POS, 0, longint'($signed(motor_pos_pred)) - PosJump - 1);
    send_beat(CMD_CLEAR, 0, 0);
    send_beat(CMD_SET_POS, 0, longint'($signed(motor_pos_pred)) - PosJump);
    send_beat(CMD_SET_SPD, 32767, 0);                   // largest positive request
    send_beat(CMD_CLEAR, 0, 0);
    send_beat(CMD_SET_SPD, -32768, 0);                  // most negative request
    send_beat(CMD_RAISE, 0, 0);
    send_beat(CMD_CLEAR, 0, 0);
    send_beat(CMD_SET_POS, 0, 32'h7FFF_FFFF);           // far jump faults
    send_beat(CMD_ESTOP, 0, 0);
    send_beat(CMD_CLEAR, 0, 0);
    send_beat(CMD_SET_SPD, 0, 0);                       // zero target clears moving

    // Random part. State carries over between phases, so a lower limit often
    // meets a speed that is already beyond it.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_config(PhaseMax[p], PhaseAccel[p]);
      speed_lim = int'(PhaseMax[p][MaxW-1:0]);
      case (p / 2)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      stop_at = beats_sent + PhaseBeats;
      while (beats_sent < stop_at) begin
        // Once, mid-phase, the sender waits for the block to empty completely.
        if (p == 3 && !paused && beats_sent >= stop_at - 50) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 75) run_motion_sequence();
        else send_noise();
      end
    end

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_cnt == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[motor_speed_ramp_integrator_unit.f]
rtl/msri_pkg.sv
rtl/motor_speed_ramp_integrator_unit.sv
tb/motor_ramp_checker.sv
tb/motor_speed_ramp_integrator_unit_test.sv
